### src/mult_bounds_propagator_defines.svh
// Assertion macros for the multiplication bounds propagator
`ifndef MULT_BOUNDS_PROPAGATOR_DEFINES_SVH
`define MULT_BOUNDS_PROPAGATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define MBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MBP_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBP_ASSERT(label, clk, rst, prop, msg)
`define MBP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### src/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants of the multiplication bounds propagator.
// ----------------------------------------------------------------------------
`default_nettype none
package mbp_pkg;
   localparam int FieldWidth = 32;
   localparam int WideWidth  = 66;

   localparam logic [1:0] OUT_NO_CHANGE = 2'd0;
   localparam logic [1:0] OUT_NARROWED  = 2'd1;
   localparam logic [1:0] OUT_CONTRA    = 2'd2;

   typedef struct packed {
      logic signed [31:0] x_lo;
      logic signed [31:0] x_hi;
      logic signed [31:0] y_lo;
      logic signed [31:0] y_hi;
      logic signed [31:0] z_lo;
      logic signed [31:0] z_hi;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x_lo;
      logic signed [31:0] new_x_hi;
      logic signed [31:0] new_y_lo;
      logic signed [31:0] new_y_hi;
      logic signed [31:0] new_z_lo;
      logic signed [31:0] new_z_hi;
      logic [1:0]         outcome;
   } rsp_type;

   // shared unit operations
   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic                        start;
      op_type                      op;
      logic signed [WideWidth-1:0] a;
      logic signed [WideWidth-1:0] b;
   } unit_cmd_type;

   typedef struct packed {
      logic                        done;
      logic signed [WideWidth-1:0] res;
      logic                        rem_nz;
   } unit_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_ISSUE,
      ST_MUL_WAIT,
      ST_Z_NARROW,
      ST_Q_SETUP,
      ST_DIV_ISSUE,
      ST_DIV_WAIT,
      ST_Q_NARROW,
      ST_ROUND_END,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

### src/mbp_arith.sv
// ----------------------------------------------------------------------------
// mbp_arith
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mbp_arith (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mbp_pkg::unit_cmd_type cmd,
   output mbp_pkg::unit_rsp_type      rsp
);
   import mbp_pkg::*;
   `include "mult_bounds_propagator_defines.svh"

   localparam int W  = WideWidth;
   localparam int CW = $clog2(W + 1);

   logic            busy_ff, busy_in;
   op_type          op_ff, op_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]    acc_ff, acc_in;   // product or remainder
   logic [W-1:0]    sh_ff, sh_in;     // multiplier or quotient
   logic [W-1:0]    den_ff, den_in;   // multiplicand or divisor magnitude
   logic            neg_ff, neg_in;   // result sign
   logic            done_ff, done_in;
   logic [W-1:0]    ua, ub, trial;
   logic [W:0]      rem_sh;

   // magnitudes of the operands
   assign ua = cmd.a[W-1] ? W'(-cmd.a) : W'(cmd.a);
   assign ub = cmd.b[W-1] ? W'(-cmd.b) : W'(cmd.b);
   assign rem_sh = {acc_ff, sh_ff[W-1]};
   assign trial  = W'(rem_sh) - den_ff;

   // step the shared unit
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CW'(W);
         acc_in  = '0;
         sh_in   = (cmd.op == OP_MUL) ? ub : ua;
         den_in  = (cmd.op == OP_MUL) ? ua : ub;
         neg_in  = cmd.a[W-1] ^ cmd.b[W-1];
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               if (sh_ff[0]) acc_in = acc_ff + den_ff;
               den_in = den_ff << 1;
               sh_in  = sh_ff >> 1;
            end
            OP_DIV: begin
               if (rem_sh[W] || (W'(rem_sh) >= den_ff)) begin
                  acc_in = trial;
                  sh_in  = {sh_ff[W-2:0], 1'b1};
               end else begin
                  acc_in = W'(rem_sh);
                  sh_in  = {sh_ff[W-2:0], 1'b0};
               end
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // signed truncating result
   always_comb begin
      rsp.done   = done_ff;
      rsp.rem_nz = (acc_ff != '0);
      if (op_ff == OP_MUL) rsp.res = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
      else                 rsp.res = neg_ff ? -$signed(sh_ff) : $signed(sh_ff);
   end

   `MBP_ASSERT(a_done_pulse, clock, reset, done_ff |=> !done_ff, "done held")
   `MBP_ASSERT(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "stray done")
   `MBP_ASSERT(a_cnt_idle, clock, reset, !busy_ff |-> cnt_ff == '0 || done_ff || $past(reset), "count left")
endmodule
`default_nettype wire

### src/mult_bounds_propagator.sv
// ----------------------------------------------------------------------------
// mult_bounds_propagator
// Bounds consistency for x * y = z, iterated to a fixpoint.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one transaction of six bounds (x, y, z lo/hi). The block
//   accepts a transaction when req_valid is high and req_stall low, only
//   while it is idle. rsp_ returns one transaction with the narrowed bounds
//   and an outcome: no change, narrowed, or contradiction (bounds zero).
//   Each round is four products plus up to eight divisions on one shared
//   66-bit unit at one bit per cycle; rounds repeat until no bound changes
//   or a contradiction is found.
//   A result waits in its output register while rsp_stall is high; the next
//   request is taken once it has left.
//   Synchronous reset empties the block and drops any work in progress.
// ----------------------------------------------------------------------------
`default_nettype none
module mult_bounds_propagator #(
   parameter int BOUND_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mbp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mbp_pkg::rsp_type      rsp_data
);
   import mbp_pkg::*;
   `include "mult_bounds_propagator_defines.svh"

   localparam int W = WideWidth;
   localparam logic signed [W-1:0] BMAX = W'((64'sd1 <<< (BOUND_WIDTH - 1)) - 1);
   localparam logic signed [W-1:0] BMIN = -BMAX - W'(1);

   typedef logic signed [W-1:0] wide_type;

   state_type       st_ff, st_in;
   wide_type        lo_ff [3], lo_in [3];
   wide_type        hi_ff [3], hi_in [3];
   logic [1:0]      rnd_ff, rnd_in, all_ff, all_in;
   logic            contra_ff, contra_in;
   logic [2:0]      k_ff, k_in;        // operation index within a phase
   logic            qv_ff, qv_in;      // 0: narrow x, 1: narrow y
   wide_type        tlo_ff, tlo_in, thi_ff, thi_in; // running min / max
   wide_type        dl_ff, dl_in, dh_ff, dh_in;     // trimmed divisor
   logic            rv_ff, rv_in;
   rsp_type         rsp_ff, rsp_in;
   unit_cmd_type    cmd;
   unit_rsp_type    ursp;
   wide_type        opa, opb, qd, qf, qc, al, ah, m, nl, nh;
   logic [1:0]      nr;

   function automatic wide_type clampb(input logic signed [31:0] v);
      wide_type e;
      e = W'(v);
      if (e < BMIN) return BMIN;
      if (e > BMAX) return BMAX;
      return e;
   endfunction

   mbp_arith u_arith (.clock(clock), .reset(reset), .cmd(cmd), .rsp(ursp));

   // dividend of the current division phase
   assign al = lo_ff[2];
   assign ah = hi_ff[2];
   assign m  = ((al < 0 ? -al : al) > (ah < 0 ? -ah : ah)) ? (al < 0 ? -al : al)
                                                           : (ah < 0 ? -ah : ah);
   // floor and ceiling from truncating quotient
   assign qd = ursp.res;
   assign qf = (ursp.rem_nz && (opa[W-1] != opb[W-1])) ? qd - W'(1) : qd;
   assign qc = (ursp.rem_nz && (opa[W-1] == opb[W-1])) ? qd + W'(1) : qd;

   // operand selection for product k or quotient k
   always_comb begin
      if (st_ff == ST_MUL_ISSUE || st_ff == ST_MUL_WAIT) begin
         opa = k_ff[0] ? hi_ff[0] : lo_ff[0];
         opb = k_ff[1] ? hi_ff[1] : lo_ff[1];
      end else begin
         opa = k_ff[1] ? ah : al;
         opb = k_ff[0] ? dh_ff : dl_ff;
      end
   end

   // intersect target with [tlo, thi]
   always_comb begin
      logic [1:0] t;
      t  = qv_ff ? 2'd1 : 2'd0;
      if (st_ff == ST_Z_NARROW) t = 2'd2;
      nl = lo_ff[t];
      nh = hi_ff[t];
      nr = OUT_NO_CHANGE;
      if (thi_ff < nh) begin nh = thi_ff; nr = OUT_NARROWED; end
      if (tlo_ff > nl) begin nl = tlo_ff; nr = OUT_NARROWED; end
      if (nl > nh) nr = OUT_CONTRA;
   end

   // sequencer
   always_comb begin
      logic [1:0] t;
      logic       dz, az;
      st_in = st_ff;
      for (int i = 0; i < 3; i++) begin lo_in[i] = lo_ff[i]; hi_in[i] = hi_ff[i]; end
      rnd_in = rnd_ff; all_in = all_ff; contra_in = contra_ff;
      k_in = k_ff; qv_in = qv_ff; tlo_in = tlo_ff; thi_in = thi_ff;
      dl_in = dl_ff; dh_in = dh_ff; rv_in = rv_ff; rsp_in = rsp_ff;
      cmd.start = 1'b0; cmd.op = OP_MUL; cmd.a = opa; cmd.b = opb;
      req_stall = (st_ff != ST_IDLE) || rv_ff;
      t = qv_ff ? 2'd1 : 2'd0;
      dz = 1'b0; az = 1'b0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               lo_in[0] = clampb(req_data.x_lo); hi_in[0] = clampb(req_data.x_hi);
               lo_in[1] = clampb(req_data.y_lo); hi_in[1] = clampb(req_data.y_hi);
               lo_in[2] = clampb(req_data.z_lo); hi_in[2] = clampb(req_data.z_hi);
               all_in = OUT_NO_CHANGE; contra_in = 1'b0;
               st_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (lo_ff[0] > hi_ff[0] || lo_ff[1] > hi_ff[1] || lo_ff[2] > hi_ff[2]) begin
               contra_in = 1'b1; st_in = ST_OUT;
            end else begin
               rnd_in = OUT_NO_CHANGE; k_in = '0; st_in = ST_MUL_ISSUE;
            end
         end
         ST_MUL_ISSUE: begin
            cmd.start = 1'b1; cmd.op = OP_MUL; st_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (ursp.done) begin
               if (k_ff == 3'd0 || ursp.res < tlo_ff) tlo_in = ursp.res;
               if (k_ff == 3'd0 || ursp.res > thi_ff) thi_in = ursp.res;
               k_in = k_ff + 3'd1;
               st_in = (k_ff == 3'd3) ? ST_Z_NARROW : ST_MUL_ISSUE;
            end
         end
         ST_Z_NARROW: begin
            lo_in[2] = nl; hi_in[2] = nh;
            if (nr == OUT_CONTRA) begin contra_in = 1'b1; st_in = ST_OUT; end
            else begin
               if (nr > rnd_ff) rnd_in = nr;
               qv_in = 1'b0; st_in = ST_Q_SETUP;
            end
         end
         ST_Q_SETUP: begin
            // divisor is y for x, x for y
            dl_in = qv_ff ? lo_ff[0] : lo_ff[1];
            dh_in = qv_ff ? hi_ff[0] : hi_ff[1];
            az = !(al > 0 || ah < 0);
            dz = (dl_in <= 0) && (dh_in >= 0);
            k_in = '0;
            if (az && dz) st_in = ST_ROUND_END;
            else if (dl_in == 0 && dh_in == 0) begin contra_in = 1'b1; st_in = ST_OUT; end
            else if (dl_in < 0 && dh_in > 0) begin
               tlo_in = -m; thi_in = m; st_in = ST_Q_NARROW;
            end else begin
               if (dl_in == 0) dl_in = W'(1);
               if (dh_in == 0) dh_in = -W'(1);
               st_in = ST_DIV_ISSUE;
            end
         end
         ST_DIV_ISSUE: begin
            cmd.start = 1'b1; cmd.op = OP_DIV; st_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            cmd.op = OP_DIV;
            if (ursp.done) begin
               if (k_ff == 3'd0 || qc < tlo_ff) tlo_in = qc;
               if (k_ff == 3'd0 || qf > thi_ff) thi_in = qf;
               k_in = k_ff + 3'd1;
               if (k_ff == 3'd3) begin
                  if (((qc < tlo_ff) ? qc : tlo_ff) > ((qf > thi_ff) ? qf : thi_ff)) begin
                     contra_in = 1'b1; st_in = ST_OUT;
                  end else st_in = ST_Q_NARROW;
               end else st_in = ST_DIV_ISSUE;
            end
         end
         ST_Q_NARROW: begin
            lo_in[t] = nl; hi_in[t] = nh;
            if (nr == OUT_CONTRA) begin contra_in = 1'b1; st_in = ST_OUT; end
            else begin
               if (nr > rnd_ff) rnd_in = nr;
               st_in = ST_ROUND_END;
            end
         end
         ST_ROUND_END: begin
            if (!qv_ff) begin qv_in = 1'b1; st_in = ST_Q_SETUP; end
            else begin
               if (rnd_ff > all_ff) all_in = rnd_ff;
               st_in = (rnd_ff == OUT_NO_CHANGE) ? ST_OUT : ST_CHECK;
            end
         end
         ST_OUT: begin
            if (!rv_ff) begin
               rsp_in.new_x_lo = contra_ff ? '0 : lo_ff[0][31:0];
               rsp_in.new_x_hi = contra_ff ? '0 : hi_ff[0][31:0];
               rsp_in.new_y_lo = contra_ff ? '0 : lo_ff[1][31:0];
               rsp_in.new_y_hi = contra_ff ? '0 : hi_ff[1][31:0];
               rsp_in.new_z_lo = contra_ff ? '0 : lo_ff[2][31:0];
               rsp_in.new_z_hi = contra_ff ? '0 : hi_ff[2][31:0];
               rsp_in.outcome  = contra_ff ? OUT_CONTRA : all_ff;
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
      for (int i = 0; i < 3; i++) begin lo_ff[i] <= lo_in[i]; hi_ff[i] <= hi_in[i]; end
      rnd_ff <= rnd_in; all_ff <= all_in; contra_ff <= contra_in;
      k_ff <= k_in; qv_ff <= qv_in; tlo_ff <= tlo_in; thi_ff <= thi_in;
      dl_ff <= dl_in; dh_ff <= dh_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   `MBP_ASSERT(a_idle_take, clock, reset, (req_valid && !req_stall) |=> st_ff == ST_CHECK, "lost request")
   `MBP_ASSERT(a_hold_rsp, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "dropped result")
   `MBP_ASSERT(a_outcome, clock, reset, rsp_valid |-> rsp_data.outcome != 2'd3, "bad outcome")
   `MBP_ASSERT(a_contra_zero, clock, reset, (rsp_valid && rsp_data.outcome == OUT_CONTRA) |-> rsp_data.new_x_lo == '0 && rsp_data.new_z_hi == '0, "contradiction bounds")
endmodule
`default_nettype wire
